// ===== hdl/ttphs_pkg.sv =====
// Shared types, codes and the microcode program for the triangle point hit search.
package ttphs_pkg;

    localparam int ENTRY_IDX_W = 6;
    localparam int FIELD_COORD_W = 10;
    localparam int TRI_COUNT_W = 7;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic [ENTRY_IDX_W-1:0]   entry_index;
        logic [FIELD_COORD_W-1:0] vertex_a_x;
        logic [FIELD_COORD_W-1:0] vertex_a_y;
        logic [FIELD_COORD_W-1:0] vertex_b_x;
        logic [FIELD_COORD_W-1:0] vertex_b_y;
        logic [FIELD_COORD_W-1:0] vertex_c_x;
        logic [FIELD_COORD_W-1:0] vertex_c_y;
        logic [FIELD_COORD_W-1:0] point_x;
        logic [FIELD_COORD_W-1:0] point_y;
    } in_item_t;

    typedef struct packed {
        logic                   hit;
        logic [ENTRY_IDX_W-1:0] hit_index;
    } out_item_t;

    typedef logic [2:0] step_t;

    localparam step_t ST_IDLE  = 3'd0;
    localparam step_t ST_CHECK = 3'd1;
    localparam step_t ST_EDGE0 = 3'd2;
    localparam step_t ST_EDGE1 = 3'd3;
    localparam step_t ST_EDGE2 = 3'd4;
    localparam step_t ST_TEST  = 3'd5;
    localparam step_t ST_DONE  = 3'd6;

    typedef enum logic [1:0] {
        EDGE_AB,
        EDGE_BC,
        EDGE_CA
    } edge_sel_t;

    typedef enum logic [2:0] {
        JC_ALWAYS,
        JC_QUERY,
        JC_END,
        JC_HIT,
        JC_OUT_FREE
    } jcond_t;

    typedef struct packed {
        logic      accept;
        logic      rd_en;
        logic      mul_en;
        edge_sel_t edge_sel;
        logic      cap0;
        logic      cap1;
        logic      test;
        logic      post;
        jcond_t    cond;
        step_t     target;
        step_t     alt;
    } uword_t;

    // One control word per step. JC_HIT takes target on a hit and alt otherwise.
    function automatic uword_t ucode_rom(input step_t pc);
        uword_t w;
        w = '{accept: 1'b0, rd_en: 1'b0, mul_en: 1'b0, edge_sel: EDGE_AB, cap0: 1'b0,
              cap1: 1'b0, test: 1'b0, post: 1'b0, cond: JC_ALWAYS, target: ST_IDLE,
              alt: ST_IDLE};
        case (pc)
            ST_IDLE: begin
                w.accept = 1'b1;
                w.cond   = JC_QUERY;
                w.target = ST_CHECK;
            end
            ST_CHECK: begin
                w.rd_en  = 1'b1;
                w.cond   = JC_END;
                w.target = ST_DONE;
            end
            ST_EDGE0: begin
                w.mul_en   = 1'b1;
                w.edge_sel = EDGE_AB;
                w.target   = ST_EDGE1;
            end
            ST_EDGE1: begin
                w.mul_en   = 1'b1;
                w.edge_sel = EDGE_BC;
                w.cap0     = 1'b1;
                w.target   = ST_EDGE2;
            end
            ST_EDGE2: begin
                w.mul_en   = 1'b1;
                w.edge_sel = EDGE_CA;
                w.cap1     = 1'b1;
                w.target   = ST_TEST;
            end
            ST_TEST: begin
                w.test   = 1'b1;
                w.cond   = JC_HIT;
                w.target = ST_DONE;
                w.alt    = ST_CHECK;
            end
            ST_DONE: begin
                w.post   = 1'b1;
                w.cond   = JC_OUT_FREE;
                w.target = ST_IDLE;
            end
            default: begin
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/ttphs_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with a registered read.
module ttphs_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 64
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/triangle_table_point_hit_search.sv =====
// Top level of the triangle table point hit search.
//
// A load transaction writes one triangle entry in its accept cycle and the block is ready
// again in the next cycle. A query transaction searches entries 0 up to the configured count
// (saturated to MAX_TRIANGLES) in order and returns one result: the lowest entry that holds
// the point, or a miss. A query is run by a microcoded sequencer that drives one shared edge
// datapath, one edge per step after a read through the read port of the triangle RAM. Inputs
// are accepted only while the sequencer idles; a finished result waits in the output register
// while the next transaction is taken. Entries must be loaded before a query searches them.
module triangle_table_point_hit_search
    import ttphs_pkg::*;
#(
    parameter int MAX_TRIANGLES = 64,
    parameter int COORD_BITS = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_wr_en,
    input  logic [TRI_COUNT_W-1:0] cfg_wr_data
);

    localparam int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int IW0 = $clog2(MAX_TRIANGLES + 1);
    localparam int CW = (IW0 > TRI_COUNT_W) ? IW0 : TRI_COUNT_W;
    localparam int CB = COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int EW = 6 * COORD_BITS;
    localparam logic [CW-1:0] MAX_EXT = CW'(MAX_TRIANGLES);

    step_t  pc_reg, pc_next;
    uword_t uw;

    logic [TRI_COUNT_W-1:0] tri_count_reg;
    logic [CW-1:0]          limit_reg, limit_next;
    logic [CW-1:0]          index_reg, index_next;
    logic [CB-1:0]          px_reg, px_next, py_reg, py_next;
    logic                   found_reg, found_next;
    logic                   sign0_reg, sign0_next, sign1_reg, sign1_next;
    logic signed [PW-1:0]   p1_reg, p1_next, p2_reg, p2_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg, m_data_next;

    logic          s_fire, load_fire, query_fire, out_free, sign_now, hit_now;
    logic [CW-1:0] cnt_ext, limit_sat;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;
    logic [CB-1:0] ax, ay, bx, by, cx, cy;
    logic [CB-1:0] x1, y1, x2, y2;
    logic signed [DW-1:0] dy, ex, dx, ey;

    assign uw = ucode_rom(pc_reg);

    assign s_ready    = uw.accept;
    assign s_fire     = s_valid && s_ready;
    assign load_fire  = s_fire && (s_data.operation == OP_LOAD);
    assign query_fire = s_fire && (s_data.operation == OP_QUERY);
    assign out_free   = !m_valid_reg || m_ready;

    assign cnt_ext   = CW'(tri_count_reg);
    assign limit_sat = (cnt_ext > MAX_EXT) ? MAX_EXT : cnt_ext;

    // Loads beyond the table are dropped.
    assign ram_we    = load_fire && (CW'(s_data.entry_index) < MAX_EXT);
    assign ram_waddr = AW'(s_data.entry_index);
    assign ram_wdata = {CB'(s_data.vertex_c_y), CB'(s_data.vertex_c_x),
                        CB'(s_data.vertex_b_y), CB'(s_data.vertex_b_x),
                        CB'(s_data.vertex_a_y), CB'(s_data.vertex_a_x)};
    assign ram_raddr = index_reg[AW-1:0];

    ttphs_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_TRIANGLES)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (uw.rd_en),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign ax = ram_rdata[0*CB +: CB];
    assign ay = ram_rdata[1*CB +: CB];
    assign bx = ram_rdata[2*CB +: CB];
    assign by = ram_rdata[3*CB +: CB];
    assign cx = ram_rdata[4*CB +: CB];
    assign cy = ram_rdata[5*CB +: CB];

    always_comb begin
        case (uw.edge_sel)
            EDGE_AB: begin
                x1 = ax; y1 = ay; x2 = bx; y2 = by;
            end
            EDGE_BC: begin
                x1 = bx; y1 = by; x2 = cx; y2 = cy;
            end
            EDGE_CA: begin
                x1 = cx; y1 = cy; x2 = ax; y2 = ay;
            end
            default: begin
                x1 = ax; y1 = ay; x2 = bx; y2 = by;
            end
        endcase
    end

    assign dy = $signed({1'b0, py_reg}) - $signed({1'b0, y1});
    assign ex = $signed({1'b0, x2}) - $signed({1'b0, x1});
    assign dx = $signed({1'b0, px_reg}) - $signed({1'b0, x1});
    assign ey = $signed({1'b0, y2}) - $signed({1'b0, y1});

    // The cross product is negative exactly when the first product is below the second.
    assign sign_now = (p1_reg < p2_reg);
    assign hit_now  = (sign0_reg == sign1_reg) && (sign1_reg == sign_now);

    always_comb begin
        pc_next      = pc_reg;
        limit_next   = limit_reg;
        index_next   = index_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        found_next   = found_reg;
        sign0_next   = sign0_reg;
        sign1_next   = sign1_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (query_fire) begin
            limit_next = limit_sat;
            index_next = '0;
            px_next    = CB'(s_data.point_x);
            py_next    = CB'(s_data.point_y);
            found_next = 1'b0;
        end

        if (uw.mul_en) begin
            p1_next = dy * ex;
            p2_next = dx * ey;
        end
        if (uw.cap0) begin
            sign0_next = sign_now;
        end
        if (uw.cap1) begin
            sign1_next = sign_now;
        end
        if (uw.test) begin
            if (hit_now) begin
                found_next = 1'b1;
            end else begin
                index_next = index_reg + 1'b1;
            end
        end
        if (uw.post && out_free) begin
            m_valid_next          = 1'b1;
            m_data_next.hit       = found_reg;
            m_data_next.hit_index = found_reg ? ENTRY_IDX_W'(index_reg) : '0;
        end

        case (uw.cond)
            JC_ALWAYS:   pc_next = uw.target;
            JC_QUERY:    pc_next = query_fire ? uw.target : pc_reg;
            JC_END:      pc_next = (index_reg >= limit_reg) ? uw.target : pc_reg + 1'b1;
            JC_HIT:      pc_next = hit_now ? uw.target : uw.alt;
            JC_OUT_FREE: pc_next = out_free ? uw.target : pc_reg;
            default:     pc_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            tri_count_reg <= '0;
        end else begin
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                tri_count_reg <= cfg_wr_data;
            end
        end
        limit_reg  <= limit_next;
        index_reg  <= index_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        found_reg  <= found_next;
        sign0_reg  <= sign0_next;
        sign1_reg  <= sign1_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
